>>> hw/rtl/hrcd_pkg.sv
// ----------------------------------------------------------------------------
// hrcd_pkg
// Shared types, sizes and the field descriptor table of the HID report
// change detector.
// ----------------------------------------------------------------------------
`default_nettype none

package hrcd_pkg;

  // Buffer and table sizes.
  localparam int REPORT_BYTES = 16;
  localparam int NUM_FIELDS   = 23;
  localparam int TABLE_LEN    = 23;
  localparam int WALK_FIELDS  = (NUM_FIELDS < TABLE_LEN) ? NUM_FIELDS : TABLE_LEN;

  localparam int BUF_AW  = (REPORT_BYTES > 1) ? $clog2(REPORT_BYTES) : 1;
  localparam int POS_W   = $clog2(REPORT_BYTES + 1);
  localparam int PREV_AW = (WALK_FIELDS > 1) ? $clog2(WALK_FIELDS) : 1;
  localparam int FIELD_W = $clog2(WALK_FIELDS + 1);

  // Field number of the home button.
  localparam logic [4:0] HOME_FIELD = 5'd20;

  // Field masks.
  localparam logic [15:0] MASK_AXIS   = 16'd65535;
  localparam logic [15:0] MASK_TRIG   = 16'd1023;
  localparam logic [15:0] MASK_HAT    = 16'd15;
  localparam logic [15:0] MASK_BUTTON = 16'd1;

  typedef struct packed {
    logic [7:0]  off;
    logic [1:0]  nbytes;
    logic [2:0]  shift;
    logic [15:0] mask;
  } field_desc_t;

  // Buffer read request from the walker to the two buffer copies.
  typedef struct packed {
    logic              re;
    logic [BUF_AW-1:0] addr_lo;
    logic [BUF_AW-1:0] addr_hi;
  } buf_rd_t;

  typedef enum logic [1:0] {
    WS_IDLE,
    WS_WALK,
    WS_FLUSH
  } walk_state_e;

  function automatic field_desc_t desc_f(input logic [4:0] idx);
    field_desc_t d;
    d = '0;
    case (idx)
      5'd0:  d = '{off: 8'd0,  nbytes: 2'd2, shift: 3'd0, mask: MASK_AXIS};
      5'd1:  d = '{off: 8'd2,  nbytes: 2'd2, shift: 3'd0, mask: MASK_AXIS};
      5'd2:  d = '{off: 8'd4,  nbytes: 2'd2, shift: 3'd0, mask: MASK_AXIS};
      5'd3:  d = '{off: 8'd6,  nbytes: 2'd2, shift: 3'd0, mask: MASK_AXIS};
      5'd4:  d = '{off: 8'd8,  nbytes: 2'd2, shift: 3'd0, mask: MASK_TRIG};
      5'd5:  d = '{off: 8'd10, nbytes: 2'd2, shift: 3'd0, mask: MASK_TRIG};
      5'd6:  d = '{off: 8'd12, nbytes: 2'd1, shift: 3'd0, mask: MASK_HAT};
      5'd7:  d = '{off: 8'd13, nbytes: 2'd1, shift: 3'd0, mask: MASK_BUTTON};
      5'd8:  d = '{off: 8'd13, nbytes: 2'd1, shift: 3'd1, mask: MASK_BUTTON};
      5'd9:  d = '{off: 8'd13, nbytes: 2'd1, shift: 3'd2, mask: MASK_BUTTON};
      5'd10: d = '{off: 8'd13, nbytes: 2'd1, shift: 3'd3, mask: MASK_BUTTON};
      5'd11: d = '{off: 8'd13, nbytes: 2'd1, shift: 3'd4, mask: MASK_BUTTON};
      5'd12: d = '{off: 8'd13, nbytes: 2'd1, shift: 3'd5, mask: MASK_BUTTON};
      5'd13: d = '{off: 8'd13, nbytes: 2'd1, shift: 3'd6, mask: MASK_BUTTON};
      5'd14: d = '{off: 8'd13, nbytes: 2'd1, shift: 3'd7, mask: MASK_BUTTON};
      5'd15: d = '{off: 8'd14, nbytes: 2'd1, shift: 3'd0, mask: MASK_BUTTON};
      5'd16: d = '{off: 8'd14, nbytes: 2'd1, shift: 3'd1, mask: MASK_BUTTON};
      5'd17: d = '{off: 8'd14, nbytes: 2'd1, shift: 3'd2, mask: MASK_BUTTON};
      5'd18: d = '{off: 8'd14, nbytes: 2'd1, shift: 3'd3, mask: MASK_BUTTON};
      5'd19: d = '{off: 8'd14, nbytes: 2'd1, shift: 3'd4, mask: MASK_BUTTON};
      5'd20: d = '{off: 8'd14, nbytes: 2'd1, shift: 3'd5, mask: MASK_BUTTON};
      5'd21: d = '{off: 8'd14, nbytes: 2'd1, shift: 3'd6, mask: MASK_BUTTON};
      5'd22: d = '{off: 8'd15, nbytes: 2'd1, shift: 3'd0, mask: MASK_BUTTON};
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/hid_report_change_detector.sv
// ----------------------------------------------------------------------------
// hid_report_change_detector
// Collects gamepad input reports byte by byte and emits a record for each
// report field whose value changed since the previous report.
// ----------------------------------------------------------------------------
// The slave channel takes one report byte per word, tagged in tuser with its
// characteristic index; tlast closes a report. Words of other characteristics
// are taken and dropped. Matching bytes go into a two-copy buffer memory, one
// per cycle while no walk is in progress.
// After the closing byte, tready stays low while the field table is walked:
// one field per cycle through the buffer and previous-value memories while the
// walk does not stall, plus pipeline fill and drain and a flush state that
// releases the last record.
// A record is held back one step so its tlast can be set; the walk stalls
// only when the master channel holds a record and a further one is due.
// The master channel carries the field number and value in tdata, the stop
// request in tuser and tlast on the final record of a report.
// Reset clears the buffer and previous values through per-entry valid bits,
// clears the first-report flag and sets the characteristic register to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module hid_report_change_detector (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,   // report_characteristic
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] report_byte
  input  wire logic [7:0]  s_axis_tuser,  // [7:0] channel_index
  input  wire logic        s_axis_tlast,  // byte_last
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // [4:0] field_number, [20:5] field_value
  output logic             m_axis_tuser,  // [0] stop_request
  output logic             m_axis_tlast   // change_last
);

  localparam int POS_W_L = hrcd_pkg::POS_W;

  logic [7:0]         report_char_q;
  logic [POS_W_L-1:0] pos_q, pos_d;
  logic               busy, take, buf_we, start;
  logic [7:0]         buf_lo, buf_hi;
  hrcd_pkg::buf_rd_t  buf_rd;

  assign s_axis_tready = !busy;
  assign take   = s_axis_tvalid && s_axis_tready && (s_axis_tuser == report_char_q);
  assign buf_we = take && (pos_q < POS_W_L'(hrcd_pkg::REPORT_BYTES));
  assign start  = take && s_axis_tlast;

  always_comb begin
    pos_d = pos_q;
    if (start) begin
      pos_d = '0;
    end else if (buf_we) begin
      pos_d = pos_q + POS_W_L'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      report_char_q <= 8'd0;
      pos_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        report_char_q <= cfg_wdata_i;
      end
      pos_q <= pos_d;
    end
  end

  // Two identical copies give the walker both bytes of a field at once.
  hrcd_ram #(
    .DATA_W (8),
    .DEPTH  (hrcd_pkg::REPORT_BYTES)
  ) u_buf_lo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (buf_we),
    .waddr_i (pos_q[hrcd_pkg::BUF_AW-1:0]),
    .wdata_i (s_axis_tdata),
    .re_i    (buf_rd.re),
    .raddr_i (buf_rd.addr_lo),
    .rdata_o (buf_lo)
  );

  hrcd_ram #(
    .DATA_W (8),
    .DEPTH  (hrcd_pkg::REPORT_BYTES)
  ) u_buf_hi (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (buf_we),
    .waddr_i (pos_q[hrcd_pkg::BUF_AW-1:0]),
    .wdata_i (s_axis_tdata),
    .re_i    (buf_rd.re),
    .raddr_i (buf_rd.addr_hi),
    .rdata_o (buf_hi)
  );

  hrcd_walker u_walker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_o        (busy),
    .buf_rd_o      (buf_rd),
    .buf_lo_i      (buf_lo),
    .buf_hi_i      (buf_hi),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

>>> hw/rtl/hrcd_ram.sv
// ----------------------------------------------------------------------------
// hrcd_ram
// Single-port-write, single-port-read synchronous RAM with registered read
// data and per-entry valid bits; an entry never written reads as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module hrcd_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid_q;
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= valid_q[raddr_i] ? mem[raddr_i] : '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/hrcd_walker.sv
// ----------------------------------------------------------------------------
// hrcd_walker
// Walks the field table over the report buffer, compares each field with its
// stored previous value and emits change records through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hrcd_walker (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  output hrcd_pkg::buf_rd_t        buf_rd_o,
  input  wire logic [7:0]          buf_lo_i,
  input  wire logic [7:0]          buf_hi_i,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [23:0]              m_axis_tdata,  // [4:0] field_number, [20:5] field_value
  output logic                     m_axis_tuser,  // [0] stop_request
  output logic                     m_axis_tlast   // change_last
);

  localparam int FIELD_W_L = hrcd_pkg::FIELD_W;
  localparam logic [FIELD_W_L-1:0] LAST_IDX = FIELD_W_L'(hrcd_pkg::WALK_FIELDS);

  hrcd_pkg::walk_state_e state_q, state_d;

  logic [FIELD_W_L-1:0] issue_idx_q, issue_idx_d;
  logic                 cmp_v_q, cmp_v_d;
  logic                 seen_q, seen_d;
  logic                 pend_v_q, pend_v_d;
  logic                 out_v_q, out_v_d;

  logic [FIELD_W_L-1:0] cmp_idx_q, cmp_idx_d;
  logic                 cmp_lo_zero_q, cmp_lo_zero_d;
  logic                 cmp_hi_zero_q, cmp_hi_zero_d;
  logic [4:0]           pend_num_q, pend_num_d;
  logic [15:0]          pend_val_q, pend_val_d;
  logic                 pend_stop_q, pend_stop_d;
  logic [4:0]           out_num_q, out_num_d;
  logic [15:0]          out_val_q, out_val_d;
  logic                 out_stop_q, out_stop_d;
  logic                 out_last_q, out_last_d;

  hrcd_pkg::field_desc_t iss_desc, cmp_desc;
  logic [7:0]  hi_off;
  logic        issuing, issue_fire, changed, out_free, adv, prev_we;
  logic [15:0] word, value, prev_rdata;
  logic [4:0]  cmp_num;

  // Issue stage: table lookup and memory addresses.
  assign iss_desc = hrcd_pkg::desc_f(5'(issue_idx_q));
  assign hi_off   = iss_desc.off + 8'd1;
  assign issuing  = (state_q == hrcd_pkg::WS_WALK) && (issue_idx_q < LAST_IDX);

  // Compare stage: little-endian assembly, shift, mask.
  assign cmp_desc = hrcd_pkg::desc_f(5'(cmp_idx_q));
  assign word     = {cmp_hi_zero_q ? 8'd0 : buf_hi_i, cmp_lo_zero_q ? 8'd0 : buf_lo_i};
  assign value    = (word >> cmp_desc.shift) & cmp_desc.mask;
  assign cmp_num  = 5'(cmp_idx_q) + 5'd1;
  assign changed  = cmp_v_q && seen_q && (prev_rdata != value);

  // A change with a record already pending needs room in the output register.
  assign out_free   = !out_v_q || m_axis_tready;
  assign adv        = !(changed && pend_v_q && !out_free);
  assign issue_fire = issuing && adv;

  assign buf_rd_o.re      = issue_fire;
  assign buf_rd_o.addr_lo = iss_desc.off[hrcd_pkg::BUF_AW-1:0];
  assign buf_rd_o.addr_hi = hi_off[hrcd_pkg::BUF_AW-1:0];

  hrcd_ram #(
    .DATA_W (16),
    .DEPTH  (hrcd_pkg::WALK_FIELDS)
  ) u_prev_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (prev_we),
    .waddr_i (cmp_idx_q[hrcd_pkg::PREV_AW-1:0]),
    .wdata_i (value),
    .re_i    (issue_fire),
    .raddr_i (issue_idx_q[hrcd_pkg::PREV_AW-1:0]),
    .rdata_o (prev_rdata)
  );

  always_comb begin
    state_d       = state_q;
    issue_idx_d   = issue_idx_q;
    cmp_v_d       = cmp_v_q;
    seen_d        = seen_q;
    pend_v_d      = pend_v_q;
    out_v_d       = out_v_q && !m_axis_tready;
    cmp_idx_d     = cmp_idx_q;
    cmp_lo_zero_d = cmp_lo_zero_q;
    cmp_hi_zero_d = cmp_hi_zero_q;
    pend_num_d    = pend_num_q;
    pend_val_d    = pend_val_q;
    pend_stop_d   = pend_stop_q;
    out_num_d     = out_num_q;
    out_val_d     = out_val_q;
    out_stop_d    = out_stop_q;
    out_last_d    = out_last_q;
    prev_we       = 1'b0;

    case (state_q)
      hrcd_pkg::WS_IDLE: begin
        if (start_i) begin
          state_d     = hrcd_pkg::WS_WALK;
          issue_idx_d = '0;
        end
      end
      hrcd_pkg::WS_WALK: begin
        if (adv) begin
          cmp_v_d = issue_fire;
          if (issue_fire) begin
            issue_idx_d   = issue_idx_q + FIELD_W_L'(1);
            cmp_idx_d     = issue_idx_q;
            cmp_lo_zero_d = iss_desc.off >= 8'(hrcd_pkg::REPORT_BYTES);
            cmp_hi_zero_d = (iss_desc.nbytes != 2'd2) ||
                            (hi_off >= 8'(hrcd_pkg::REPORT_BYTES));
          end
          if (cmp_v_q) begin
            prev_we = 1'b1;
          end
          if (changed) begin
            // The pending record is not the last one: pass it on.
            if (pend_v_q) begin
              out_v_d    = 1'b1;
              out_num_d  = pend_num_q;
              out_val_d  = pend_val_q;
              out_stop_d = pend_stop_q;
              out_last_d = 1'b0;
            end
            pend_v_d    = 1'b1;
            pend_num_d  = cmp_num;
            pend_val_d  = value;
            pend_stop_d = (cmp_num == hrcd_pkg::HOME_FIELD) && (value == 16'd1);
          end
        end
        if (!issuing && !cmp_v_q) begin
          state_d = hrcd_pkg::WS_FLUSH;
          seen_d  = 1'b1;
        end
      end
      hrcd_pkg::WS_FLUSH: begin
        if (!pend_v_q) begin
          state_d = hrcd_pkg::WS_IDLE;
        end else if (out_free) begin
          out_v_d    = 1'b1;
          out_num_d  = pend_num_q;
          out_val_d  = pend_val_q;
          out_stop_d = pend_stop_q;
          out_last_d = 1'b1;
          pend_v_d   = 1'b0;
          state_d    = hrcd_pkg::WS_IDLE;
        end
      end
      default: begin
        state_d = hrcd_pkg::WS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hrcd_pkg::WS_IDLE;
      issue_idx_q <= '0;
      cmp_v_q     <= 1'b0;
      seen_q      <= 1'b0;
      pend_v_q    <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      issue_idx_q <= issue_idx_d;
      cmp_v_q     <= cmp_v_d;
      seen_q      <= seen_d;
      pend_v_q    <= pend_v_d;
      out_v_q     <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q     <= cmp_idx_d;
    cmp_lo_zero_q <= cmp_lo_zero_d;
    cmp_hi_zero_q <= cmp_hi_zero_d;
    pend_num_q    <= pend_num_d;
    pend_val_q    <= pend_val_d;
    pend_stop_q   <= pend_stop_d;
    out_num_q     <= out_num_d;
    out_val_q     <= out_val_d;
    out_stop_q    <= out_stop_d;
    out_last_q    <= out_last_d;
  end

  assign busy_o        = (state_q != hrcd_pkg::WS_IDLE);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {3'd0, out_val_q, out_num_q};
  assign m_axis_tuser  = out_stop_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the HID report change detector. Report bytes are
// streamed in as directed cases and then as randomized reports, with foreign
// channel words mixed in. A behavioral copy of the report buffer and the
// previous field values predicts every change record, and each record on the
// output stream is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int MAX_SHOWN       = 10;

  typedef struct packed {
    logic [4:0]  num;
    logic [15:0] value;
    logic        stop;
    logic        last;
  } change_rec_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [7:0]  cfg_wdata_i   = 8'h00;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] report_byte
  logic [7:0]  s_axis_tuser  = 8'h00;  // [7:0] channel_index
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;           // [4:0] field_number, [20:5] field_value
  logic        m_axis_tuser;           // [0] stop_request
  logic        m_axis_tlast;

  // Predicted state of the block.
  logic [7:0]  report_chan;
  logic [7:0]  rpt_buf [hrcd_pkg::REPORT_BYTES];
  int unsigned rpt_pos;
  logic [15:0] last_value [hrcd_pkg::WALK_FIELDS];
  bit          first_done;

  change_rec_t pending_changes[$];
  int          mismatches;
  int unsigned watchdog;
  int          sent_items;
  bit          idle_on = 1'b1;
  // Pad state that the random reports evolve from.
  logic [7:0]  pad_state [hrcd_pkg::REPORT_BYTES];

  hid_report_change_detector u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [7:0] buf_at(input int pos);
    if (pos >= hrcd_pkg::REPORT_BYTES) begin
      return 8'h00;
    end
    return rpt_buf[pos];
  endfunction

  // Field layout: four 16-bit axes, two 10-bit triggers, a 4-bit hat and
  // single-bit buttons in bytes 13 to 15.
  function automatic logic [15:0] field_value(input int idx);
    int          off;
    int          shamt;
    bit          two;
    logic [15:0] mask;
    logic [15:0] raw;
    two   = 1'b0;
    shamt = 0;
    mask  = 16'h0001;
    if (idx < 4) begin
      off  = 2 * idx;
      two  = 1'b1;
      mask = 16'hFFFF;
    end else if (idx < 6) begin
      off  = 8 + 2 * (idx - 4);
      two  = 1'b1;
      mask = 16'h03FF;
    end else if (idx == 6) begin
      off  = 12;
      mask = 16'h000F;
    end else if (idx < 15) begin
      off   = 13;
      shamt = idx - 7;
    end else if (idx < 22) begin
      off   = 14;
      shamt = idx - 15;
    end else begin
      off = 15;
    end
    raw = {(two ? buf_at(off + 1) : 8'h00), buf_at(off)};
    return (raw >> shamt) & mask;
  endfunction

  task automatic absorb_byte(input logic [7:0] chan, input logic [7:0] data,
                             input logic last);
    change_rec_t rec;
    logic [15:0] v;
    int          first_idx;
    if (chan != report_chan) begin
      return;
    end
    if (rpt_pos < hrcd_pkg::REPORT_BYTES) begin
      rpt_buf[rpt_pos] = data;
      rpt_pos++;
    end
    if (!last) begin
      return;
    end
    first_idx = pending_changes.size();
    for (int i = 0; i < hrcd_pkg::WALK_FIELDS; i++) begin
      v = field_value(i);
      if (first_done && v != last_value[i]) begin
        rec.num   = 5'(i + 1);
        rec.value = v;
        rec.stop  = (5'(i + 1) == hrcd_pkg::HOME_FIELD) && (v == 16'd1);
        rec.last  = 1'b0;
        pending_changes.push_back(rec);
      end
      last_value[i] = v;
    end
    if (pending_changes.size() > first_idx) begin
      pending_changes[pending_changes.size() - 1].last = 1'b1;
    end
    rpt_pos    = 0;
    first_done = 1'b1;
  endtask

  task automatic send_word(input logic [7:0] chan, input logic [7:0] data,
                           input logic last);
    int gap;
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 99) < 7) begin
      gap = $urandom_range(1, 5);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= chan;
    s_axis_tdata  <= data;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_items++;
    absorb_byte(chan, data, last);
  endtask

  // Drops valid, then lets every predicted record drain and the walk finish.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_changes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_report_chan(input logic [7:0] chan);
    settle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= chan;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    report_chan = chan;
  endtask

  function automatic logic [7:0] foreign_chan();
    return report_chan ^ 8'($urandom_range(1, 255));
  endfunction

  task automatic send_random_report(input int len);
    int nmut;
    int pos;
    if ($urandom_range(0, 9) == 0) begin
      foreach (pad_state[k]) pad_state[k] = 8'($urandom);
    end else begin
      nmut = $urandom_range(0, 3);
      repeat (nmut) begin
        pos = $urandom_range(0, hrcd_pkg::REPORT_BYTES - 1);
        if ($urandom_range(0, 1) == 1) begin
          pad_state[pos] ^= 8'h01 << $urandom_range(0, 7);
        end else begin
          pad_state[pos] = 8'($urandom);
        end
      end
      // Toggle the home button often enough to see stop requests.
      if ($urandom_range(0, 3) == 0) begin
        pad_state[14][4] = ~pad_state[14][4];
      end
    end
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(foreign_chan(), 8'($urandom), 1'($urandom_range(0, 1)));
      end
      send_word(report_chan,
                (k < hrcd_pkg::REPORT_BYTES) ? pad_state[k] : 8'($urandom),
                k == len - 1);
    end
  endtask

  // The register still holds its reset value here.
  task automatic test_reset_channel();
    send_word(8'd0, 8'h5A, 1'b1);
    send_word(8'd1, 8'hFF, 1'b1);
  endtask

  // An overlong all-ones report moves every field, then a short report of
  // zeros changes only the first axis.
  task automatic test_full_swing();
    write_report_chan(8'hFF);
    for (int k = 0; k < hrcd_pkg::REPORT_BYTES + 1; k++) begin
      send_word(8'hFF, 8'hFF, k == hrcd_pkg::REPORT_BYTES);
    end
    send_word(8'hFF, 8'h00, 1'b0);
    send_word(8'hFF, 8'h00, 1'b1);
    send_word(8'h00, 8'hAA, 1'b1);
  endtask

  task automatic test_random_reports(input logic [7:0] chan, input bit idling,
                                     input int budget);
    int stop_at;
    int r;
    int len;
    write_report_chan(chan);
    idle_on = idling;
    stop_at = sent_items + budget;
    while (sent_items < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        len = hrcd_pkg::REPORT_BYTES;
      end else if (r < 90) begin
        len = $urandom_range(1, hrcd_pkg::REPORT_BYTES - 1);
      end else begin
        len = $urandom_range(hrcd_pkg::REPORT_BYTES + 1, hrcd_pkg::REPORT_BYTES + 4);
      end
      send_random_report(len);
    end
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= !(idle_on && $urandom_range(0, 99) < 7);
  end

  always @(posedge clk_i) begin : check_records
    change_rec_t got;
    change_rec_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{num: m_axis_tdata[4:0], value: m_axis_tdata[20:5],
              stop: m_axis_tuser, last: m_axis_tlast};
      if (pending_changes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $display("unexpected record: field %0d value %h stop %b last %b",
                   got.num, got.value, got.stop, got.last);
        end
      end else begin
        want = pending_changes.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("record mismatch: expected field %0d value %h stop %b last %b",
                     want.num, want.value, want.stop, want.last);
            $display("                 got      field %0d value %h stop %b last %b",
                     got.num, got.value, got.stop, got.last);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      watchdog <= 0;
    end else if (watchdog == WATCHDOG_CYCLES) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      watchdog <= watchdog + 1;
    end
  end

  initial begin
    report_chan = 8'h00;
    rpt_pos     = 0;
    first_done  = 1'b0;
    mismatches  = 0;
    watchdog    = 0;
    sent_items  = 0;
    foreach (rpt_buf[k]) rpt_buf[k] = 8'h00;
    foreach (pad_state[k]) pad_state[k] = 8'h00;
    foreach (last_value[k]) last_value[k] = 16'h0000;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_channel();
    test_full_swing();
    test_random_reports(8'($urandom_range(1, 254)), 1'b1, 100);
    test_random_reports(8'h00, 1'b0, 100);
    test_random_reports(8'($urandom), 1'b1, 100);

    idle_on = 1'b1;
    settle();
    if (mismatches == 0 && pending_changes.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
hw/rtl/hrcd_pkg.sv
hw/rtl/hrcd_ram.sv
hw/rtl/hrcd_walker.sv
hw/rtl/hid_report_change_detector.sv
bench/tb.sv
